@@ rtl/p1305_pkg.sv @@
// Shared types, constants and helpers for the Poly1305 MAC block.
// No dependencies; every other file in rtl/ imports this package.
package p1305_pkg;

    localparam int LIMB_W = 26;
    localparam logic [63:0] CLAMP_LOW  = 64'h0fff_fffc_0fff_ffff;
    localparam logic [63:0] CLAMP_HIGH = 64'h0fff_fffc_0fff_fffc;
    localparam logic [31:0] LIMB_MASK  = 32'h03ff_ffff;
    localparam logic [31:0] LIMB_TOP   = 32'h0400_0000;

    // configuration register indexes
    localparam logic [1:0] REG_R_LOW  = 2'd0;
    localparam logic [1:0] REG_R_HIGH = 2'd1;
    localparam logic [1:0] REG_S_LOW  = 2'd2;
    localparam logic [1:0] REG_S_HIGH = 2'd3;

    typedef struct packed {
        logic [63:0] block_low;
        logic [63:0] block_high;
        logic [4:0]  byte_count;
        logic        is_last;
    } in_t;

    typedef struct packed {
        logic [63:0] tag_low;
        logic [63:0] tag_high;
    } out_t;

    typedef struct packed {
        logic [4:0][25:0] t;
        logic             absorb;
        logic             last;
    } cmd_t;

    typedef struct packed {
        logic [63:0] r_low;
        logic [63:0] r_high;
        logic [63:0] s_low;
        logic [63:0] s_high;
    } key_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIN1,
        ST_FIN2,
        ST_FIN3
    } state_t;

endpackage

@@ rtl/p1305_regs.sv @@
// APB register file holding the 256-bit one-time key.
// Depends on p1305_pkg.
module p1305_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    output p1305_pkg::key_t     key
);
    import p1305_pkg::*;

    key_t key_reg;
    key_t key_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign key    = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (wr_en)
        begin
            case (paddr[4:3])
                REG_R_LOW:  key_next.r_low  = pwdata;
                REG_R_HIGH: key_next.r_high = pwdata;
                REG_S_LOW:  key_next.s_low  = pwdata;
                REG_S_HIGH: key_next.s_high = pwdata;
                default:    key_next = key_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            REG_R_LOW:  prdata = key_reg.r_low;
            REG_R_HIGH: prdata = key_reg.r_high;
            REG_S_LOW:  prdata = key_reg.s_low;
            REG_S_HIGH: prdata = key_reg.s_high;
            default:    prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_reg <= '0;
        else
            key_reg <= key_next;
    end

endmodule

@@ rtl/p1305_front.sv @@
// Front end: masks the block to its byte count, adds the pad bit and
// splits it into 26-bit limbs. Depends on p1305_pkg.
module p1305_front (
    input  p1305_pkg::in_t  blk,
    output p1305_pkg::cmd_t cmd
);
    import p1305_pkg::*;

    logic [4:0]   cnt;
    logic [127:0] data;
    logic [135:0] m;

    always_comb
    begin
        cnt  = (blk.byte_count > 5'd16) ? 5'd16 : blk.byte_count;
        data = {blk.block_high, blk.block_low};
        m    = '0;
        for (int b = 0; b < 16; b++)
        begin
            if (5'(b) < cnt)
                m[8*b +: 8] = data[8*b +: 8];
        end
        // pad bit sits just above the last valid byte
        for (int b = 1; b <= 16; b++)
        begin
            if (5'(b) == cnt)
                m[8*b] = 1'b1;
        end
        for (int i = 0; i < 5; i++)
            cmd.t[i] = m[26*i +: 26];
        cmd.absorb = (cnt != 5'd0);
        cmd.last   = blk.is_last;
    end

endmodule

@@ rtl/p1305_cmdq.sv @@
// Two-entry queue of classified blocks between front and back end.
// Depends on p1305_pkg.
module p1305_cmdq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  p1305_pkg::cmd_t din,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output p1305_pkg::cmd_t dout
);
    import p1305_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign dout    = mem_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wp_reg] <= din;
    end

endmodule

@@ rtl/p1305_tagq.sv @@
// Two-entry output queue for finished tags.
// Depends on p1305_pkg.
module p1305_tagq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  p1305_pkg::out_t din,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output p1305_pkg::out_t dout
);
    import p1305_pkg::*;

    out_t       mem_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign dout    = mem_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wp_reg] <= din;
    end

endmodule

@@ rtl/p1305_core.sv @@
// Back end: multiply-by-r modulo 2^130-5, one product limb per cycle,
// then final reduction and addition of s. Depends on p1305_pkg.
module p1305_core (
    input  logic            clk,
    input  logic            rst_n,
    input  p1305_pkg::key_t key,
    input  logic            cmd_valid,
    input  p1305_pkg::cmd_t cmd,
    output logic            cmd_pop,
    input  logic            tag_ready,
    output logic            tag_push,
    output p1305_pkg::out_t tag
);
    import p1305_pkg::*;

    state_t            state_reg, state_next;
    logic [2:0]        k_reg, k_next;
    logic [4:0][26:0]  acc_reg, acc_next;
    cmd_t              cur_reg, cur_next;
    logic [4:0][27:0]  hop_reg, hop_next;
    logic [37:0]       c_reg, c_next;
    logic [4:0][31:0]  fh_reg, fh_next;
    logic [127:0]      pk_reg, pk_next;

    logic [127:0]      rc;
    logic [4:0][25:0]  r;
    logic [4:0][28:0]  r5;
    logic [4:0][27:0]  hm;
    logic [63:0]       dsum;
    logic [56:0]       prod;
    logic [28:0]       coef;
    logic [2:0]        idx;
    logic [31:0]       c32, h0n, h1n;
    logic [31:0]       f0, f1, f2, f3, f4, fc;
    logic [31:0]       g0, g1, g2, g3, g4, gc;
    logic [31:0]       s0, s1, s2, s3, s4;
    logic [63:0]       lo, hi;
    logic              can_take;

    // clamped r and its multiples by five
    always_comb
    begin
        rc = {key.r_high & CLAMP_HIGH, key.r_low & CLAMP_LOW};
        for (int i = 0; i < 5; i++)
        begin
            r[i]  = (i == 4) ? {2'b00, rc[127:104]} : rc[26*i +: 26];
            r5[i] = 29'(r[i]) * 29'd5;
        end
    end

    // one column of the schoolbook product per cycle
    always_comb
    begin
        dsum = 64'(c_reg);
        for (int j = 0; j < 5; j++)
        begin
            hm[j] = (k_reg == 3'd0) ? (28'(acc_reg[j]) + 28'(cur_reg.t[j])) : hop_reg[j];
            idx   = (k_reg >= 3'(j)) ? (k_reg - 3'(j)) : (k_reg + 3'd5 - 3'(j));
            coef  = (k_reg >= 3'(j)) ? 29'(r[idx]) : r5[idx];
            prod  = 57'(hm[j]) * 57'(coef);
            dsum  = dsum + 64'(prod);
        end
        // wrap the top carry back in with weight five
        c32 = dsum[57:26];
        h0n = 32'(acc_reg[0]) + c32 * 32'd5;
        h1n = 32'(acc_reg[1]) + (h0n >> 26);
    end

    // final carry pass
    always_comb
    begin
        f0 = 32'(acc_reg[0]);
        f1 = 32'(acc_reg[1]);
        f2 = 32'(acc_reg[2]);
        f3 = 32'(acc_reg[3]);
        f4 = 32'(acc_reg[4]);
        fc = f1 >> 26; f1 = f1 & LIMB_MASK; f2 = f2 + fc;
        fc = f2 >> 26; f2 = f2 & LIMB_MASK; f3 = f3 + fc;
        fc = f3 >> 26; f3 = f3 & LIMB_MASK; f4 = f4 + fc;
        fc = f4 >> 26; f4 = f4 & LIMB_MASK; f0 = f0 + fc * 32'd5;
        fc = f0 >> 26; f0 = f0 & LIMB_MASK; f1 = f1 + fc;
    end

    // subtract p where h is at least p, then pack to 128 bits
    always_comb
    begin
        g0 = fh_reg[0] + 32'd5;  gc = g0 >> 26; g0 = g0 & LIMB_MASK;
        g1 = fh_reg[1] + gc;     gc = g1 >> 26; g1 = g1 & LIMB_MASK;
        g2 = fh_reg[2] + gc;     gc = g2 >> 26; g2 = g2 & LIMB_MASK;
        g3 = fh_reg[3] + gc;     gc = g3 >> 26; g3 = g3 & LIMB_MASK;
        g4 = fh_reg[4] + gc;
        if (g4 >= LIMB_TOP)
        begin
            s0 = g0; s1 = g1; s2 = g2; s3 = g3; s4 = g4 - LIMB_TOP;
        end
        else
        begin
            s0 = fh_reg[0]; s1 = fh_reg[1]; s2 = fh_reg[2];
            s3 = fh_reg[3]; s4 = fh_reg[4];
        end
        lo = 64'(s0) | (64'(s1) << 26) | (64'(s2) << 52);
        hi = (64'(s2) >> 12) | (64'(s3) << 14) | (64'(s4) << 40);
    end

    assign {tag.tag_high, tag.tag_low} = pk_reg + {key.s_high, key.s_low};
    assign tag_push = (state_reg == ST_FIN3) && tag_ready;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        acc_next   = acc_reg;
        cur_next   = cur_reg;
        hop_next   = hop_reg;
        c_next     = c_reg;
        fh_next    = fh_reg;
        pk_next    = pk_reg;
        can_take   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                can_take = 1'b1;
            end
            ST_MUL:
            begin
                if (k_reg == 3'd0)
                    hop_next = hm;
                c_next = dsum[63:26];
                acc_next[k_reg] = 27'(dsum[25:0]);
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd4)
                begin
                    acc_next[0] = 27'(h0n[25:0]);
                    acc_next[1] = h1n[26:0];
                    if (cur_reg.last)
                        state_next = ST_FIN1;
                    else
                    begin
                        can_take   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FIN1:
            begin
                fh_next    = {f4, f3, f2, f1, f0};
                acc_next   = '0;
                state_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                pk_next    = {hi, lo};
                state_next = ST_FIN3;
            end
            ST_FIN3:
            begin
                if (tag_ready)
                begin
                    can_take   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        cmd_pop = can_take && cmd_valid;
        if (cmd_pop)
        begin
            cur_next = cmd;
            k_next   = 3'd0;
            c_next   = '0;
            if (cmd.absorb)
                state_next = ST_MUL;
            else if (cmd.last)
                state_next = ST_FIN1;
            else
                state_next = ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= 3'd0;
            acc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        hop_reg <= hop_next;
        c_reg   <= c_next;
        fh_reg  <= fh_next;
        pk_reg  <= pk_next;
    end

endmodule

@@ rtl/poly1305_mac.sv @@
// Poly1305 MAC top level. A full or short block passes through the
// back end's five-limb multiply, which yields one limb per cycle; the
// back end takes the next block of a message in the multiply's last step.
// A last block then passes the final reduction states ST_FIN1 to ST_FIN3
// and waits in ST_FIN3 until the tag queue has room; an empty last block
// goes straight to the final reduction.
// Reset (rst_n, asynchronous, active low) clears the key, the accumulator
// and both queues.
module poly1305_mac (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  p1305_pkg::in_t  blk,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output p1305_pkg::out_t tag,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [4:0]      paddr,
    input  logic [63:0]     pwdata,
    output logic [63:0]     prdata,
    output logic            pready
);
    import p1305_pkg::*;

    key_t key;
    cmd_t front_cmd, q_cmd;
    logic q_empty, q_pop;
    logic t_full, t_push;
    out_t t_data;

    p1305_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .key     (key)
    );

    p1305_front u_front (
        .blk (blk),
        .cmd (front_cmd)
    );

    p1305_cmdq u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_cmd),
        .full  (full),
        .pop   (q_pop),
        .empty (q_empty),
        .dout  (q_cmd)
    );

    p1305_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key),
        .cmd_valid (!q_empty),
        .cmd       (q_cmd),
        .cmd_pop   (q_pop),
        .tag_ready (!t_full),
        .tag_push  (t_push),
        .tag       (t_data)
    );

    p1305_tagq u_tagq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (t_push),
        .din   (t_data),
        .full  (t_full),
        .pop   (pop),
        .empty (empty),
        .dout  (tag)
    );

endmodule

@@ rtl/p1305_check.sv @@
// Port-level checks for poly1305_mac, attached by bind.
// Depends on p1305_pkg.
module p1305_check (
    input logic            clk,
    input logic            rst_n,
    input logic            full,
    input logic            pop,
    input logic            empty,
    input p1305_pkg::out_t tag,
    input logic            pready
);
    import p1305_pkg::*;

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    a_tag_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(tag))
        else $error("waiting tag changed");

    a_tag_stay: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting tag lost");

    a_reset_clear: assert property (@(posedge clk)
        (rst_n && !$past(rst_n)) |-> (empty && !full))
        else $error("queues not clear after reset");

endmodule

bind poly1305_mac p1305_check u_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .full   (full),
    .pop    (pop),
    .empty  (empty),
    .tag    (tag),
    .pready (pready)
);

@@ sim/tb_poly1305_mac.sv @@
// Self-checking testbench for the Poly1305 MAC block (poly1305_mac).
// Depends on rtl/p1305_pkg.sv and rtl/poly1305_mac.sv; predicts tags with
// wide-integer arithmetic modulo 2^130-5 and checks them in order.
module tb_poly1305_mac;
    timeunit 1ns;
    timeprecision 1ps;
    import p1305_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        push;
    in_t         blk;
    logic        full;
    logic        pop;
    logic        empty;
    out_t        tag;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    poly1305_mac u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .blk(blk), .full(full),
        .pop(pop), .empty(empty), .tag(tag), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    // key copy and accumulator of the predictor
    logic [63:0]  key_r_low, key_r_high, key_s_low, key_s_high;
    logic [129:0] acc_h;

    in_t  block_queue[$];
    out_t tag_queue[$];
    int   error_count;
    int   cycle_count;
    int   tags_seen;
    bit   in_taken;
    bit   hold_pop;
    int   hold_cycles;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    // absorb one block into the predicted accumulator; return a tag on last
    function automatic bit poly_absorb(input in_t item, output out_t result);
        logic [4:0]   count;
        logic [129:0] r;
        logic [128:0] msg;
        logic [259:0] prod;
        logic [130:0] h;
        logic [127:0] s;
        count = (item.byte_count > 5'd16) ? 5'd16 : item.byte_count;
        r = {2'b0, key_r_high & CLAMP_HIGH, key_r_low & CLAMP_LOW};
        if (count != 5'd0)
        begin
            msg = {1'b0, item.block_high, item.block_low};
            if (count != 5'd16)
                msg = msg & ((129'd1 << (8 * count)) - 129'd1);
            msg = msg | (129'd1 << (8 * count));
            prod = ({130'd0, acc_h} + {131'd0, msg}) * {130'd0, r};
            acc_h = 130'(prod % ((260'd1 << 130) - 260'd5));
        end
        if (!item.is_last)
            return 1'b0;
        h = {1'b0, acc_h};
        s = {key_s_high, key_s_low};
        h = h + {3'b0, s};
        result.tag_low = h[63:0];
        result.tag_high = h[127:64];
        acc_h = '0;
        return 1'b1;
    endfunction

    task automatic apb_write(input logic [1:0] index, input logic [63:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {index, 3'b000};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (index)
            REG_R_LOW:  key_r_low = value;
            REG_R_HIGH: key_r_high = value;
            REG_S_LOW:  key_s_low = value;
            default:    key_s_high = value;
        endcase
    endtask

    task automatic load_key(input logic [63:0] rl, input logic [63:0] rh,
                            input logic [63:0] sl, input logic [63:0] sh);
        apb_write(REG_R_LOW, rl);
        apb_write(REG_R_HIGH, rh);
        apb_write(REG_S_LOW, sl);
        apb_write(REG_S_HIGH, sh);
    endtask

    // wait for the block to drain: queue empty, no expectations, then slack
    task automatic wait_drained();
        while (block_queue.size() != 0 || push || tag_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic in_t make_block(input int count, input bit last);
        in_t item;
        item.block_low = rand64();
        item.block_high = rand64();
        item.byte_count = 5'(count);
        item.is_last = last;
        return item;
    endfunction

    // random message: full blocks then a tail that is often short
    task automatic queue_message(input int nblocks);
        int k;
        for (k = 0; k < nblocks - 1; k++)
            block_queue.push_back(make_block(16, 1'b0));
        case ($urandom_range(0, 9))
            0:       block_queue.push_back(make_block(0, 1'b1));
            1:       block_queue.push_back(make_block($urandom_range(17, 31), 1'b1));
            2, 3, 4: block_queue.push_back(make_block(16, 1'b1));
            default: block_queue.push_back(make_block($urandom_range(1, 15), 1'b1));
        endcase
    endtask

    // driver: offer items from the queue with random gaps
    always @(negedge clk)
    begin
        int gap;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else if (!push || in_taken)
        begin
            if (block_queue.size() == 0)
                push <= 1'b0;
            else
            begin
                gap = $urandom_range(0, 6);
                if ($urandom_range(0, 3) == 0)
                    gap = 0;
                if (gap > 0)
                begin
                    push <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                blk <= block_queue[0];
                push <= 1'b1;
            end
        end
    end

    // predict on every accepted transfer
    always @(posedge clk)
    begin
        out_t result;
        in_taken <= rst_n && push && !full;
        if (rst_n && push && !full)
        begin
            if (poly_absorb(blk, result))
                tag_queue.push_back(result);
            void'(block_queue.pop_front());
        end
    end

    // receiver: random stalls, plus a long hold-off when asked
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_pop)
            pop <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            pop <= 1'b0;
        end
        else if ($urandom_range(0, 1) == 0)
            pop <= 1'b1;
        else
        begin
            pop <= 1'b0;
            hold_cycles <= $urandom_range(0, 6);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && pop && !empty)
        begin
            if (tag_queue.size() == 0)
            begin
                report_mismatch("unexpected tag", tag.tag_low, 64'd0);
            end
            else
            begin
                want = tag_queue.pop_front();
                tags_seen++;
                if (tag.tag_low !== want.tag_low)
                    report_mismatch("tag_low", tag.tag_low, want.tag_low);
                if (tag.tag_high !== want.tag_high)
                    report_mismatch("tag_high", tag.tag_high, want.tag_high);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int k;
        int phase;
        int items;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        blk = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        key_r_low = '0;
        key_r_high = '0;
        key_s_low = '0;
        key_s_high = '0;
        acc_h = '0;
        error_count = 0;
        cycle_count = 0;
        tags_seen = 0;
        in_taken = 1'b0;
        hold_pop = 1'b0;
        hold_cycles = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (3) @(posedge clk);

        // directed: a fixed test key and edge cases
        load_key(64'h33d9_b541_6ab6_0f85, 64'h4901_0806_a8fd_e3bf,
                 64'hf63f_8043_2e19_9c80, 64'h1bf5_4941_aff6_bf4a);
        block_queue.push_back(make_block(0, 1'b1));                  // empty message
        block_queue.push_back('{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                                5'd16, 1'b0});
        block_queue.push_back('{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                                5'd31, 1'b1});                       // saturated count
        block_queue.push_back('{64'h0, 64'h0, 5'd16, 1'b1});
        for (k = 1; k <= 15; k++)
            block_queue.push_back(make_block(k, k[0]));              // short, masked tail
        block_queue.push_back(make_block(7, 1'b0));                  // short not last
        block_queue.push_back(make_block(0, 1'b1));
        wait_drained();

        // random phases with changing keys, extremes included
        items = 0;
        for (phase = 0; items < 2000; phase++)
        begin
            case (phase % 4)
                0:  load_key('0, '0, '0, '0);
                1:  load_key('1, '1, '1, '1);
                default: load_key(rand64(), rand64(), rand64(), rand64());
            endcase
            if (phase == 2)
            begin
                // long hold-off so the block fills and stalls its input
                hold_pop = 1'b1;
                for (k = 0; k < 30; k++)
                    queue_message(1);
                items += 30;
                repeat (600) @(posedge clk);
                hold_pop = 1'b0;
            end
            for (k = 0; k < 40; k++)
            begin
                int n;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12)
                                                 : $urandom_range(1, 4);
                queue_message(n);
                items += n;
            end
            wait_drained();
        end
        repeat (50) @(posedge clk);
        if (error_count == 0 && tag_queue.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
